@@ hdl/sfp_pkg.sv @@
// Shared types and constants for the sensor frame parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sfp_pkg;

   localparam int MAX_PAYLOAD = 8;
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 4;
   localparam int PAYLOAD_W   = 64;
   localparam int STORE_IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_FIRST   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_SECOND  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_LENGTH = 2'd2;

   localparam logic [BYTE_W-1:0] HEADER_FIRST_RST   = 8'h55;
   localparam logic [BYTE_W-1:0] HEADER_SECOND_RST  = 8'h53;
   localparam logic [LEN_W-1:0]  PAYLOAD_LENGTH_RST = LEN_W'(MAX_PAYLOAD);

   typedef struct packed {
      logic [BYTE_W-1:0] header_first;
      logic [BYTE_W-1:0] header_second;
      logic [LEN_W-1:0]  payload_length;
   } cfg_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_HDR1 = 3'b010,
      PH_DATA = 3'b100
   } phase_type;

   // length register clamped to 1..MAX_PAYLOAD
   function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] n;
      n = len;
      if (n == '0) n = LEN_W'(1);
      if (n > LEN_W'(MAX_PAYLOAD)) n = LEN_W'(MAX_PAYLOAD);
      return n;
   endfunction

endpackage

`default_nettype wire

@@ hdl/sfp_csr.sv @@
// Configuration registers of the frame parser: header bytes and payload length.
// Depends on sfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfp_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [sfp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sfp_pkg::CSR_DATA_W-1:0] csr_wr_data,
   output sfp_pkg::cfg_type                   cfg
);
   import sfp_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HEADER_FIRST:   cfg_in.header_first   = csr_wr_data[BYTE_W-1:0];
            CSR_HEADER_SECOND:  cfg_in.header_second  = csr_wr_data[BYTE_W-1:0];
            CSR_PAYLOAD_LENGTH: cfg_in.payload_length = csr_wr_data[LEN_W-1:0];
            default: ; // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_first   <= HEADER_FIRST_RST;
         cfg_ff.header_second  <= HEADER_SECOND_RST;
         cfg_ff.payload_length <= PAYLOAD_LENGTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ hdl/sfp_in_reg.sv @@
// Input register stage: captures one received byte per item.
// Depends on sfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfp_in_reg (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [sfp_pkg::BYTE_W-1:0] req_rx_byte,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output logic [sfp_pkg::BYTE_W-1:0]      out_byte
);
   import sfp_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              take;

   assign req_ready = !valid_ff || out_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req_rx_byte;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;

endmodule

`default_nettype wire

@@ hdl/sfp_parser.sv @@
// Frame parser state machine, payload store, checksum and result register.
// Depends on sfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfp_parser (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire sfp_pkg::cfg_type             cfg,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic [sfp_pkg::BYTE_W-1:0]    in_byte,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [sfp_pkg::PAYLOAD_W-1:0]      rsp_frame_payload,
   output logic                              rsp_frame_status
);
   import sfp_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [BYTE_W-1:0] store_ff [MAX_PAYLOAD];
   logic              store_we;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PAYLOAD_W-1:0] payload_ff, payload_in;
   logic                 status_ff, status_in;

   logic                 fire, emit;
   logic [LEN_W-1:0]     len;
   logic [PAYLOAD_W-1:0] packed_payload;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign fire     = in_valid && in_ready;
   assign len      = eff_length(cfg.payload_length);

   // bytes below the current length come from the store, the rest read zero
   always_comb begin
      packed_payload = '0;
      for (int i = 0; i < MAX_PAYLOAD; i++) begin
         if (LEN_W'(i) < len) packed_payload[BYTE_W*i +: BYTE_W] = store_ff[i];
      end
   end

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      store_we = 1'b0;
      emit     = 1'b0;
      if (fire) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (in_byte == cfg.header_first) phase_in = PH_HDR1;
            end
            PH_HDR1: begin
               if (in_byte == cfg.header_second) begin
                  count_in = '0;
                  sum_in   = cfg.header_first + cfg.header_second;
                  phase_in = PH_DATA;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_DATA: begin
               if (count_ff < len) begin
                  store_we = 1'b1;
                  sum_in   = sum_ff + in_byte;
                  count_in = count_ff + LEN_W'(1);
               end else begin
                  emit     = 1'b1;
                  phase_in = PH_IDLE;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   // payload store, written only during the data phase of a frame
   always_ff @(posedge clock) begin
      if (store_we) store_ff[count_ff[STORE_IDX_W-1:0]] <= in_byte;
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      payload_in   = payload_ff;
      status_in    = status_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         payload_in   = packed_payload;
         status_in    = (in_byte != sum_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
      status_ff  <= status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_payload = payload_ff;
   assign rsp_frame_status  = status_ff;

endmodule

`default_nettype wire

@@ hdl/sensor_frame_parser_checksum.sv @@
// Sensor frame parser with two-byte header and 8-bit sum checksum.
// Throughput: one byte item per cycle; stalls only while a result waits on rsp_ready.
// Path: an accepted checksum byte goes through the input register, then the parser
//   and result register, and raises rsp_valid.
// Reset: synchronous, active high; parser returns to header hunt, registers
//   reload 0x55 / 0x53 / length 8. Payload store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sensor_frame_parser_checksum (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // byte input channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [sfp_pkg::BYTE_W-1:0]     req_rx_byte,
   // frame result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [sfp_pkg::PAYLOAD_W-1:0]       rsp_frame_payload,
   output logic                               rsp_frame_status,
   // configuration write port
   input  wire logic                          csr_wr_en,
   input  wire logic [sfp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sfp_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import sfp_pkg::*;

   cfg_type           cfg;
   logic              stg_valid;
   logic              stg_ready;
   logic [BYTE_W-1:0] stg_byte;

   // header bytes and length; user writes only while no item is in flight; unenforced
   sfp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   // input register: keeps req_ready high while the result side flows
   sfp_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .out_valid   (stg_valid),
      .out_ready   (stg_ready),
      .out_byte    (stg_byte)
   );

   // header hunt, payload collection, checksum compare; result register inside.
   // Only the checksum byte of a frame produces an item on rsp_*.
   sfp_parser u_parser (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .in_valid          (stg_valid),
      .in_ready          (stg_ready),
      .in_byte           (stg_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_payload (rsp_frame_payload),
      .rsp_frame_status  (rsp_frame_status)
   );

endmodule

`default_nettype wire

@@ tb/sfp_frame_checker.sv @@
// Frame checker for the sensor frame parser: watches the byte, result and csr ports.
// Predicts each frame result and compares it with what the block returns.
// Depends on sfp_pkg for widths, register indexes, reset values and phase codes.
`timescale 1ns / 1ps

module sfp_frame_checker
   import sfp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic [BYTE_W-1:0]     req_rx_byte,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic [PAYLOAD_W-1:0]  rsp_frame_payload,
   input  wire logic                  rsp_frame_status,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data,
   output int                         mismatch_count,
   output int                         pending_frames,
   output int                         frames_checked
);

   typedef struct packed {
      logic [PAYLOAD_W-1:0] payload;
      logic                 status;
   } frame_result_t;

   frame_result_t     frames_q[$];

   // shadow registers
   logic [BYTE_W-1:0] hdr_first;
   logic [BYTE_W-1:0] hdr_second;
   logic [LEN_W-1:0]  len_reg;

   // parser state
   phase_type         phase;
   logic [LEN_W-1:0]  bytes_in;
   logic [BYTE_W-1:0] frame_sum;
   logic [BYTE_W-1:0] body [MAX_PAYLOAD];

   int fail_tally = 0;
   int checked    = 0;

   task automatic note_failure(input string what);
      fail_tally++;
      if (fail_tally <= 10) $display("%0t frame check: %s", $time, what);
   endtask

   task automatic take_byte(input logic [BYTE_W-1:0] b);
      int            limit;
      int            i;
      frame_result_t res;
      // length 0 acts as 1, anything above the store depth as the depth
      if (len_reg == '0) limit = 1;
      else if (int'(len_reg) > MAX_PAYLOAD) limit = MAX_PAYLOAD;
      else limit = int'(len_reg);
      case (phase)
         PH_IDLE: begin
            if (b == hdr_first) phase = PH_HDR1;
         end
         PH_HDR1: begin
            // a wrong second byte is not retried as a first header
            if (b == hdr_second) begin
               bytes_in  = '0;
               frame_sum = hdr_first + hdr_second;
               phase     = PH_DATA;
            end else begin
               phase = PH_IDLE;
            end
         end
         PH_DATA: begin
            if (int'(bytes_in) < limit) begin
               body[bytes_in[STORE_IDX_W-1:0]] = b;
               frame_sum = frame_sum + b;
               bytes_in  = bytes_in + 1'b1;
            end else begin
               res.payload = '0;
               for (i = 0; i < limit; i++) res.payload[8*i +: 8] = body[i];
               res.status = (b != frame_sum);
               frames_q.push_back(res);
               phase = PH_IDLE;
            end
         end
         default: phase = PH_IDLE;
      endcase
   endtask

   task automatic check_result();
      frame_result_t want;
      if (frames_q.size() == 0) begin
         note_failure($sformatf("unexpected frame: payload %h status %b",
                                rsp_frame_payload, rsp_frame_status));
      end else begin
         want = frames_q.pop_front();
         checked++;
         if (rsp_frame_payload !== want.payload)
            note_failure($sformatf("payload: expected %h, got %h",
                                   want.payload, rsp_frame_payload));
         if (rsp_frame_status !== want.status)
            note_failure($sformatf("status: expected %b, got %b",
                                   want.status, rsp_frame_status));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         hdr_first  = HEADER_FIRST_RST;
         hdr_second = HEADER_SECOND_RST;
         len_reg    = PAYLOAD_LENGTH_RST;
         phase      = PH_IDLE;
         bytes_in   = '0;
         frame_sum  = '0;
         frames_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_HEADER_FIRST:   hdr_first  = csr_wr_data;
               CSR_HEADER_SECOND:  hdr_second = csr_wr_data;
               CSR_PAYLOAD_LENGTH: len_reg    = csr_wr_data[LEN_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) take_byte(req_rx_byte);
         if (rsp_valid && rsp_ready) check_result();
      end
      mismatch_count <= fail_tally;
      pending_frames <= frames_q.size();
      frames_checked <= checked;
   end

endmodule

@@ tb/tb_sensor_frame_parser_checksum.sv @@
// Top of the sensor frame parser testbench: clock, reset, byte stimulus, result
// back-pressure and csr settings. Depends on sfp_pkg, the parser and sfp_frame_checker.
`timescale 1ns / 1ps

module tb_sensor_frame_parser_checksum;
   import sfp_pkg::*;

   // index 3 has no register behind it; writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   // checksum byte passes the input and result registers before the result; leave some margin
   localparam int DRAIN_CYCLES = 4;
   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_BYTES  = 120;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic [BYTE_W-1:0]     req_rx_byte = '0;
   logic                  rsp_ready   = 1'b0;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;
   wire                   req_ready;
   wire                   rsp_valid;
   wire [PAYLOAD_W-1:0]   rsp_frame_payload;
   wire                   rsp_frame_status;

   int mismatch_count;
   int pending_frames;
   int frames_checked;

   // stimulus view of the current settings, used to build frames
   logic [BYTE_W-1:0] cur_hf  = HEADER_FIRST_RST;
   logic [BYTE_W-1:0] cur_hs  = HEADER_SECOND_RST;
   int                cur_len = MAX_PAYLOAD;
   int                bytes_sent    = 0;
   int                settings_used = 1;
   // when set, neither side idles: back-to-back bytes and results
   bit                steady = 1'b0;

   sensor_frame_parser_checksum DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_payload (rsp_frame_payload),
      .rsp_frame_status  (rsp_frame_status),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   sfp_frame_checker frame_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_payload (rsp_frame_payload),
      .rsp_frame_status  (rsp_frame_status),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .mismatch_count    (mismatch_count),
      .pending_frames    (pending_frames),
      .frames_checked    (frames_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one byte item after a random gap and hold it until accepted.
   // Valid stays high on return so a zero gap gives back-to-back items.
   task automatic send_byte(input logic [BYTE_W-1:0] value);
      int gap;
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   // Header, count payload bytes from body (lowest byte first), then the
   // sum byte; spoil flips at least one bit of the sum.
   task automatic send_frame(input logic [PAYLOAD_W-1:0] body, input int count,
                             input logic spoil);
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] b;
      int                i;
      sum = cur_hf + cur_hs;
      send_byte(cur_hf);
      send_byte(cur_hs);
      for (i = 0; i < count; i++) begin
         b   = body[8*i +: 8];
         sum = sum + b;
         send_byte(b);
      end
      if (spoil) sum = sum ^ BYTE_W'($urandom_range(1, 255));
      send_byte(sum);
   endtask

   // Drop valid, wait for every predicted frame to come back, then let the
   // pipeline empty of bytes that produce no result.
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_frames != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all three registers plus the unmapped index, only once idle.
   task automatic set_config(input logic [CSR_DATA_W-1:0] first_val,
                             input logic [CSR_DATA_W-1:0] second_val,
                             input logic [CSR_DATA_W-1:0] len_val);
      quiesce();
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_HEADER_FIRST;
      csr_wr_data <= first_val;
      @(posedge clock);
      csr_index   <= CSR_HEADER_SECOND;
      csr_wr_data <= second_val;
      @(posedge clock);
      csr_index   <= CSR_PAYLOAD_LENGTH;
      csr_wr_data <= len_val;
      @(posedge clock);
      csr_index   <= CSR_SPARE;
      csr_wr_data <= CSR_DATA_W'($urandom);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_hf = first_val;
      cur_hs = second_val;
      // length register is 4 bits; 0 acts as 1, above the depth as the depth
      cur_len = int'(len_val[LEN_W-1:0]);
      if (cur_len == 0) cur_len = 1;
      if (cur_len > MAX_PAYLOAD) cur_len = MAX_PAYLOAD;
      settings_used++;
   endtask

   // Result side: a random stall before each result, none in steady phases.
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      int phase_idx;
      int target;
      int pick;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // Reset settings: full 8-byte payload with all-zero, all-one, single-bit
      // and single-clear-bit bytes.
      send_frame(64'hFE7F_0180_FF00_FF00, MAX_PAYLOAD, 1'b0);

      // Extreme headers, length register 0 (acts as 1), bad checksum.
      set_config(8'h00, 8'hFF, 8'h00);
      send_frame(64'hAA, 1, 1'b1);

      // Wrong second header byte: 00 00 must not restart the hunt on the
      // second 00, so the FF that follows is dropped in idle.
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(64'h5A, 1, 1'b0);

      // Settings change inside a frame. Length data F9 keeps only its low
      // nibble (9, clamped to 8). Two payload bytes go in, then the length
      // drops to 2 and the first header changes: the next byte is the
      // checksum and the sum still uses the headers seen at frame start.
      set_config(8'h00, 8'hFF, 8'hF9);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h11);
      send_byte(8'h22);
      set_config(8'h10, 8'hFF, 8'h02);
      send_byte(8'h32);

      // ---- random part ----
      // Each phase picks settings (extremes first), then mostly good frames
      // with random content, some bad sums, broken headers and line noise.
      for (phase_idx = 0; phase_idx < PHASE_COUNT; phase_idx++) begin
         case (phase_idx)
            0: set_config(8'h00, 8'h00, 8'h01);   // equal headers, shortest
            1: set_config(8'hFF, 8'h00, 8'h08);   // longest frame
            2: set_config(8'hA5, 8'hA5, 8'h00);   // length 0
            3: set_config(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom), 8'h0F);
            4: set_config(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom), 8'hF4);
            default: set_config(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                                CSR_DATA_W'($urandom));
         endcase
         steady = (phase_idx == 3 || phase_idx == 6);
         target = bytes_sent + PHASE_BYTES;
         while (bytes_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
               send_frame({$urandom, $urandom}, cur_len, 1'b0);
            end else if (pick < 80) begin
               send_frame({$urandom, $urandom}, cur_len, 1'b1);
            end else if (pick < 88) begin
               // header broken on its second byte
               send_byte(cur_hf);
               send_byte(cur_hs ^ BYTE_W'($urandom_range(1, 255)));
            end else if (pick < 94) begin
               // first header byte doubled ahead of a full frame
               send_byte(cur_hf);
               send_frame({$urandom, $urandom}, cur_len, 1'b0);
            end else begin
               repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom));
            end
         end
      end
      steady = 1'b0;

      // every item is in; wait out the remaining results and any stray ones
      quiesce();

      $display("Run covered %0d bytes under %0d register settings.",
               bytes_sent, settings_used);
      $display("%0d frames compared, %0d field mismatches.",
               frames_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // hang guard: ends a run that never finishes
   initial begin
      #3_000_000;
      $display("Timed out with %0d frames outstanding.", pending_frames);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
